// File: rtl/ffaa_pkg.sv
package ffaa_pkg;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // smallest arena a config write may set
    localparam int ARENA_MIN = 4096;

    // per-cycle operation broadcast to the extent cells
    typedef struct packed {
        logic wr;   // load write data at the write index
        logic shl;  // cells at and above the shift index take the right neighbor
        logic shr;  // cells above the shift index take the left neighbor
    } t_cell_op;

endpackage

// File: rtl/ffaa_cell.sv
module ffaa_cell #(
    parameter int AW = 20,
    parameter int IW = 4,
    parameter int K  = 0
) (
    input  logic              i_clk,
    input  ffaa_pkg::t_cell_op i_op,
    input  logic [IW-1:0]     i_idx_wr,
    input  logic [IW-1:0]     i_idx_sh,
    input  logic [AW-1:0]     i_wr_start,
    input  logic [AW:0]       i_wr_len,
    input  logic [AW-1:0]     i_left_start,
    input  logic [AW:0]       i_left_len,
    input  logic [AW-1:0]     i_right_start,
    input  logic [AW:0]       i_right_len,
    output logic [AW-1:0]     o_start,
    output logic [AW:0]       o_len
);

    logic [AW-1:0] r_start;
    logic [AW:0]   r_len;

    always_ff @(posedge i_clk) begin
        if (i_op.shr && (IW'(K) > i_idx_sh)) begin
            r_start <= i_left_start;
            r_len   <= i_left_len;
        end else if (i_op.shl && (IW'(K) >= i_idx_sh)) begin
            r_start <= i_right_start;
            r_len   <= i_right_len;
        end else if (i_op.wr && (IW'(K) == i_idx_wr)) begin
            r_start <= i_wr_start;
            r_len   <= i_wr_len;
        end
    end

    assign o_start = r_start;
    assign o_len   = r_len;

endmodule

// File: rtl/first_fit_arena_allocator_unit.sv
// an allocate scans the extent table up to the first fit, then splits or takes it, or
//   carves from the frontier when none fits; a free runs the sanity checks, scans the
//   free extents held (at most FREE_SLOTS), then merges or inserts before the o_done
//   strobe (a free failing the sanity checks ends after them)
// throughput: one item at a time; the extent scan steps one cell per cycle
// a new item may be started in the cycle o_done is high; results cannot be stalled
// reset (synchronous, active low): arena is 2^ARENA_BITS bytes, no free extents,
//   frontier at the arena top less one header, counters cleared
module first_fit_arena_allocator_unit #(
    parameter int ARENA_BITS      = 20,
    parameter int FREE_SLOTS      = 16,
    parameter int HEADER_BYTES    = 8,
    parameter int ALIGN_BYTES     = 16,
    parameter int MIN_SPLIT_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [ARENA_BITS:0]   i_request_size,
    input  logic [ARENA_BITS-1:0] i_block_address,
    input  logic [ARENA_BITS:0]   i_block_size,
    // result channel
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [ARENA_BITS-1:0] o_user_address,
    output logic [ARENA_BITS:0]   o_granted_size,
    output logic [ARENA_BITS:0]   o_bytes_in_use,
    output logic [15:0]           o_live_blocks,
    // arena size register
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [ARENA_BITS:0]   i_cfg_data
);

    localparam int AW = ARENA_BITS;
    localparam int SW = ARENA_BITS + 1;
    localparam int XW = ARENA_BITS + 3;          // headroom for sums of sizes
    localparam int CW = $clog2(FREE_SLOTS + 1);  // extent count and scan index
    localparam int IW = $clog2(FREE_SLOTS);      // cell index
    localparam logic [SW-1:0] ARENA_TOP = SW'(64'd1 << AW);
    localparam logic [15:0]   CNT_MAX   = 16'hFFFF;

    // control states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ASCAN = 3'd1;  // first fit search
    localparam logic [2:0] S_ATAKE = 3'd2;  // split or take the found extent
    localparam logic [2:0] S_FCHK  = 3'd3;  // free sanity checks
    localparam logic [2:0] S_FSCAN = 3'd4;  // overlap and position search
    localparam logic [2:0] S_FDEC  = 3'd5;  // merge, insert or return to frontier

    logic [2:0]    r_state, n_state;
    logic [SW-1:0] r_arena, n_arena;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_frontier, n_frontier;
    logic [SW-1:0] r_bytes, n_bytes;
    logic [15:0]   r_alloc_tot, n_alloc_tot;
    logic [15:0]   r_free_tot, n_free_tot;
    logic [CW-1:0] r_k, n_k;

    // latched item
    logic [SW-1:0] r_req, n_req;
    logic [AW-1:0] r_addr, n_addr;
    logic [SW-1:0] r_sz, n_sz;

    // scan findings
    logic          r_found, n_found;
    logic [CW-1:0] r_p, n_p;
    logic [AW-1:0] r_p_start, n_p_start;
    logic [SW-1:0] r_p_len, n_p_len;
    logic [AW-1:0] r_prev_start, n_prev_start;
    logic [SW-1:0] r_prev_len, n_prev_len;

    // result registers
    logic          r_done, n_done;
    logic [1:0]    r_status, n_status;
    logic [AW-1:0] r_ua, n_ua;
    logic [SW-1:0] r_gs, n_gs;

    // cell chain
    ffaa_pkg::t_cell_op w_op;
    logic [IW-1:0] w_idx_wr, w_idx_sh;
    logic [AW-1:0] w_wr_start;
    logic [SW-1:0] w_wr_len;
    logic [AW-1:0] w_cell_start [FREE_SLOTS];
    logic [SW-1:0] w_cell_len   [FREE_SLOTS];

    genvar g;
    generate
        for (g = 0; g < FREE_SLOTS; g++) begin : g_cell
            logic [AW-1:0] w_ls, w_rs;
            logic [SW-1:0] w_ll, w_rl;
            if (g == 0) begin : g_first
                assign w_ls = '0;
                assign w_ll = '0;
            end else begin : g_mid_l
                assign w_ls = w_cell_start[g-1];
                assign w_ll = w_cell_len[g-1];
            end
            if (g == FREE_SLOTS - 1) begin : g_last
                assign w_rs = '0;
                assign w_rl = '0;
            end else begin : g_mid_r
                assign w_rs = w_cell_start[g+1];
                assign w_rl = w_cell_len[g+1];
            end
            ffaa_cell #(.AW(AW), .IW(IW), .K(g)) u_cell (
                .i_clk        (i_clk),
                .i_op         (w_op),
                .i_idx_wr     (w_idx_wr),
                .i_idx_sh     (w_idx_sh),
                .i_wr_start   (w_wr_start),
                .i_wr_len     (w_wr_len),
                .i_left_start (w_ls),
                .i_left_len   (w_ll),
                .i_right_start(w_rs),
                .i_right_len  (w_rl),
                .o_start      (w_cell_start[g]),
                .o_len        (w_cell_len[g])
            );
        end
    endgenerate

    // entry under the scan index
    logic [XW-1:0] w_cs, w_cl;
    assign w_cs = XW'(w_cell_start[r_k[IW-1:0]]);
    assign w_cl = XW'(w_cell_len[r_k[IW-1:0]]);

    // rounded block size: header added, aligned up
    logic [XW-1:0] w_req_pad, w_a;
    assign w_req_pad = XW'(r_req) + XW'(HEADER_BYTES + ALIGN_BYTES - 1);
    assign w_a       = (w_req_pad / XW'(ALIGN_BYTES)) * XW'(ALIGN_BYTES);

    // block being freed
    logic [XW-1:0] w_s, w_sz, w_fr, w_end;
    assign w_s   = XW'(r_addr) - XW'(HEADER_BYTES);
    assign w_sz  = XW'(r_sz);
    assign w_fr  = XW'(r_frontier);
    assign w_end = w_s + w_sz;

    // merge decision terms
    logic [CW-1:0] w_p_eff, w_p_m1;
    logic          w_lo, w_hi;
    logic [XW-1:0] w_ms, w_ml;
    assign w_p_eff = r_found ? r_p : r_count;
    assign w_p_m1  = w_p_eff - CW'(1);
    assign w_lo    = r_found && (XW'(r_p_start) + XW'(r_p_len) == w_s);
    assign w_hi    = (w_p_eff != '0) && (w_end == XW'(r_prev_start));
    assign w_ms    = w_lo ? XW'(r_p_start) : w_s;
    assign w_ml    = (w_lo ? XW'(r_p_len) + w_sz : w_sz) + (w_hi ? XW'(r_prev_len) : '0);

    // remaining extent length on a split, and block start when carving from the frontier
    logic [XW-1:0] w_split_len, w_frontier_new;
    assign w_split_len    = XW'(r_p_len) - w_a;
    assign w_frontier_new = w_fr - w_a;

    logic [SW-1:0] w_cfg_val;
    always_comb begin
        if (i_cfg_data < SW'(ffaa_pkg::ARENA_MIN)) begin
            w_cfg_val = SW'(ffaa_pkg::ARENA_MIN);
        end else if (i_cfg_data > ARENA_TOP) begin
            w_cfg_val = ARENA_TOP;
        end else begin
            w_cfg_val = i_cfg_data;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_arena      = r_arena;
        n_count      = r_count;
        n_frontier   = r_frontier;
        n_bytes      = r_bytes;
        n_alloc_tot  = r_alloc_tot;
        n_free_tot   = r_free_tot;
        n_k          = r_k;
        n_req        = r_req;
        n_addr       = r_addr;
        n_sz         = r_sz;
        n_found      = r_found;
        n_p          = r_p;
        n_p_start    = r_p_start;
        n_p_len      = r_p_len;
        n_prev_start = r_prev_start;
        n_prev_len   = r_prev_len;
        n_done       = 1'b0;
        n_status     = r_status;
        n_ua         = r_ua;
        n_gs         = r_gs;
        w_op         = '0;
        w_idx_wr     = '0;
        w_idx_sh     = '0;
        w_wr_start   = '0;
        w_wr_len     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_request_size;
                    n_addr  = i_block_address;
                    n_sz    = i_block_size;
                    n_k     = '0;
                    n_found = 1'b0;
                    n_state = (i_command == ffaa_pkg::CMD_ALLOC) ? S_ASCAN : S_FCHK;
                end else if (i_cfg_valid) begin
                    // new arena size restarts the allocator
                    n_arena     = w_cfg_val;
                    n_count     = '0;
                    n_frontier  = w_cfg_val - SW'(HEADER_BYTES);
                    n_bytes     = '0;
                    n_alloc_tot = '0;
                    n_free_tot  = '0;
                end
            end

            S_ASCAN: begin
                if (r_k == r_count) begin
                    // nothing in the table fits: carve from untouched space
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (w_fr >= w_a) begin
                        n_frontier  = SW'(w_frontier_new);
                        n_bytes     = r_bytes + SW'(w_a);
                        n_alloc_tot = (r_alloc_tot < CNT_MAX) ? r_alloc_tot + 16'd1 : r_alloc_tot;
                        n_status    = ffaa_pkg::ST_OK;
                        n_ua        = AW'(w_frontier_new + XW'(HEADER_BYTES));
                        n_gs        = SW'(w_a);
                    end else begin
                        n_status = ffaa_pkg::ST_NOMEM;
                        n_ua     = '0;
                        n_gs     = '0;
                    end
                end else if (w_cl >= w_a) begin
                    n_p_start = AW'(w_cs);
                    n_p_len   = SW'(w_cl);
                    n_state   = S_ATAKE;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end

            S_ATAKE: begin
                n_state     = S_IDLE;
                n_done      = 1'b1;
                n_status    = ffaa_pkg::ST_OK;
                n_alloc_tot = (r_alloc_tot < CNT_MAX) ? r_alloc_tot + 16'd1 : r_alloc_tot;
                if (XW'(r_p_len) > w_a + XW'(HEADER_BYTES + MIN_SPLIT_BYTES)) begin
                    // split: block comes off the upper end
                    w_op.wr    = 1'b1;
                    w_idx_wr   = r_k[IW-1:0];
                    w_wr_start = r_p_start;
                    w_wr_len   = SW'(w_split_len);
                    n_bytes    = r_bytes + SW'(w_a);
                    n_ua       = AW'(XW'(r_p_start) + w_split_len + XW'(HEADER_BYTES));
                    n_gs       = SW'(w_a);
                end else begin
                    // take whole extent, keep its slack
                    w_op.shl = 1'b1;
                    w_idx_sh = r_k[IW-1:0];
                    n_count  = r_count - CW'(1);
                    n_bytes  = r_bytes + r_p_len;
                    n_ua     = AW'(XW'(r_p_start) + XW'(HEADER_BYTES));
                    n_gs     = r_p_len;
                end
            end

            S_FCHK: begin
                n_ua = '0;
                n_gs = '0;
                if ((XW'(r_addr) < XW'(HEADER_BYTES)) || (r_sz == '0) ||
                    ((w_sz % XW'(ALIGN_BYTES)) != '0) || (w_s < w_fr) ||
                    (w_end > XW'(r_arena) - XW'(HEADER_BYTES)) ||
                    (r_sz > r_bytes)) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ffaa_pkg::ST_BAD;
                end else begin
                    n_state = S_FSCAN;
                end
            end

            S_FSCAN: begin
                if (r_k == r_count) begin
                    n_state = S_FDEC;
                end else if ((w_s < w_cs + w_cl) && (w_cs < w_end)) begin
                    // double free
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = ffaa_pkg::ST_BAD;
                end else begin
                    n_k = r_k + CW'(1);
                    if (!r_found) begin
                        if (w_cs <= w_s) begin
                            n_found   = 1'b1;
                            n_p       = r_k;
                            n_p_start = AW'(w_cs);
                            n_p_len   = SW'(w_cl);
                        end else begin
                            n_prev_start = AW'(w_cs);
                            n_prev_len   = SW'(w_cl);
                        end
                    end
                end
            end

            S_FDEC: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_status = ffaa_pkg::ST_OK;
                if (!w_lo && !w_hi && (w_s != w_fr) &&
                    (r_count >= CW'(FREE_SLOTS))) begin
                    n_status = ffaa_pkg::ST_FULL;
                end else begin
                    n_bytes    = r_bytes - r_sz;
                    n_free_tot = (r_free_tot < CNT_MAX) ? r_free_tot + 16'd1 : r_free_tot;
                    if (!w_lo && !w_hi) begin
                        if (w_s == w_fr) begin
                            n_frontier = SW'(w_fr + w_sz);
                        end else begin
                            w_op.shr   = 1'b1;
                            w_op.wr    = 1'b1;
                            w_idx_sh   = w_p_eff[IW-1:0];
                            w_idx_wr   = w_p_eff[IW-1:0];
                            w_wr_start = AW'(w_s);
                            w_wr_len   = r_sz;
                            n_count    = r_count + CW'(1);
                        end
                    end else if (w_ms == w_fr) begin
                        // merged extent is the lowest one: hand it back to the frontier
                        n_frontier = SW'(w_fr + w_ml);
                        n_count    = r_count - ((w_lo && w_hi) ? CW'(2) : CW'(1));
                    end else begin
                        w_op.wr    = 1'b1;
                        w_wr_start = AW'(w_ms);
                        w_wr_len   = SW'(w_ml);
                        if (w_hi) begin
                            w_idx_wr = w_p_m1[IW-1:0];
                            if (w_lo) begin
                                w_op.shl = 1'b1;
                                w_idx_sh = w_p_eff[IW-1:0];
                                n_count  = r_count - CW'(1);
                            end
                        end else begin
                            w_idx_wr = w_p_eff[IW-1:0];
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_arena     <= ARENA_TOP;
            r_count     <= '0;
            r_frontier  <= ARENA_TOP - SW'(HEADER_BYTES);
            r_bytes     <= '0;
            r_alloc_tot <= '0;
            r_free_tot  <= '0;
            r_done      <= 1'b0;
            r_found     <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_arena     <= n_arena;
            r_count     <= n_count;
            r_frontier  <= n_frontier;
            r_bytes     <= n_bytes;
            r_alloc_tot <= n_alloc_tot;
            r_free_tot  <= n_free_tot;
            r_done      <= n_done;
            r_found     <= n_found;
            r_k         <= n_k;
        end
    end

    // item and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_addr       <= n_addr;
        r_sz         <= n_sz;
        r_p          <= n_p;
        r_p_start    <= n_p_start;
        r_p_len      <= n_p_len;
        r_prev_start <= n_prev_start;
        r_prev_len   <= n_prev_len;
        r_status     <= n_status;
        r_ua         <= n_ua;
        r_gs         <= n_gs;
    end

    assign busy           = (r_state != S_IDLE);
    // arena size is taken only when idle and no item is offered
    assign o_cfg_ready    = (r_state == S_IDLE) && !start;
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_user_address = r_ua;
    assign o_granted_size = r_gs;
    assign o_bytes_in_use = r_bytes;
    assign o_live_blocks  = (r_alloc_tot >= r_free_tot) ? r_alloc_tot - r_free_tot : 16'd0;

endmodule

// File: rtl/ffaa_chk.sv
module ffaa_chk #(
    parameter int ARENA_BITS = 20
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_done,
    input logic [1:0]            o_status,
    input logic [ARENA_BITS-1:0] o_user_address,
    input logic [ARENA_BITS:0]   o_granted_size
);

    // accepted item keeps the block busy next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("not busy after accepted item");

    // results come out only when the block is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");

    // one strobe per item
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    // failed items grant nothing
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ffaa_pkg::ST_OK)) |-> (o_granted_size == '0) &&
        (o_user_address == '0)) else $error("failed item carries a grant");

endmodule

bind first_fit_arena_allocator_unit ffaa_chk #(.ARENA_BITS(ARENA_BITS)) u_ffaa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_user_address(o_user_address),
    .o_granted_size(o_granted_size)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

typedef struct {
    logic [1:0]  status;
    logic [19:0] user_address;
    logic [20:0] granted_size;
    logic [20:0] bytes_in_use;
    logic [15:0] live_blocks;
} t_result;

// expected allocator results, oldest first
class alloc_scoreboard;
    t_result pending[$];
    int      errors;
    int      checked;

    function void note_item(t_result r);
        pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [19:0] ua, logic [20:0] gs,
                               logic [20:0] biu, logic [15:0] lb);
        t_result e;
        checked++;
        if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (st !== e.status) begin
            $error("status exp %0d got %0d", e.status, st);
            errors++;
        end
        if (ua !== e.user_address) begin
            $error("user_address exp %0h got %0h", e.user_address, ua);
            errors++;
        end
        if (gs !== e.granted_size) begin
            $error("granted_size exp %0h got %0h", e.granted_size, gs);
            errors++;
        end
        if (biu !== e.bytes_in_use) begin
            $error("bytes_in_use exp %0h got %0h", e.bytes_in_use, biu);
            errors++;
        end
        if (lb !== e.live_blocks) begin
            $error("live_blocks exp %0d got %0d", e.live_blocks, lb);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int HDR    = 8;
    localparam int ALIGN  = 16;
    localparam int SPLIT  = 16;
    localparam int SLOTS  = 16;
    localparam int WDOG   = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_command = ffaa_pkg::CMD_ALLOC;
    logic [20:0] i_request_size = '0;
    logic [19:0] i_block_address = '0;
    logic [20:0] i_block_size = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [19:0] o_user_address;
    logic [20:0] o_granted_size;
    logic [20:0] o_bytes_in_use;
    logic [15:0] o_live_blocks;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [20:0] i_cfg_data = '0;

    always #2 i_clk = ~i_clk;

    first_fit_arena_allocator_unit uut (.*);

    alloc_scoreboard sb = new();

    // predictor state, kept in 64-bit math like plain integers
    longint unsigned arena_sz;
    longint unsigned ext_start[SLOTS];
    longint unsigned ext_len[SLOTS];
    int              ext_cnt;
    longint unsigned frontier;
    longint unsigned in_use;
    int              alloc_cnt;
    int              free_cnt;

    // blocks handed out and not yet freed, for well-formed frees
    logic [19:0] live_addr[$];
    logic [20:0] live_size[$];

    int idle_pct;
    int watchdog;
    bit timed_out;

    function void arena_reset(longint unsigned v);
        if (v < ffaa_pkg::ARENA_MIN) v = ffaa_pkg::ARENA_MIN;
        if (v > (64'd1 << 20)) v = 64'd1 << 20;
        arena_sz  = v;
        ext_cnt   = 0;
        frontier  = v - HDR;
        in_use    = 0;
        alloc_cnt = 0;
        free_cnt  = 0;
        live_addr.delete();
        live_size.delete();
    endfunction

    function void drop_extent(int i);
        for (int k = i; k + 1 < ext_cnt; k++) begin
            ext_start[k] = ext_start[k+1];
            ext_len[k]   = ext_len[k+1];
        end
        ext_cnt--;
    endfunction

    function void insert_extent(int i, longint unsigned s, longint unsigned l);
        for (int k = ext_cnt; k > i; k--) begin
            ext_start[k] = ext_start[k-1];
            ext_len[k]   = ext_len[k-1];
        end
        ext_start[i] = s;
        ext_len[i]   = l;
        ext_cnt++;
    endfunction

    function logic [1:0] predict_alloc(longint unsigned req, output longint unsigned ua,
                                       output longint unsigned gs);
        longint unsigned need, s;
        int i;
        need = ((req + HDR + ALIGN - 1) / ALIGN) * ALIGN;
        ua = 0;
        gs = 0;
        for (i = 0; i < ext_cnt; i++)
            if (ext_len[i] >= need) break;
        if (i < ext_cnt) begin
            if (ext_len[i] > need + HDR + SPLIT) begin
                ext_len[i] -= need;
                s  = ext_start[i] + ext_len[i];
                gs = need;
            end else begin
                s  = ext_start[i];
                gs = ext_len[i];
                drop_extent(i);
            end
        end else if (frontier >= need) begin
            frontier -= need;
            s  = frontier;
            gs = need;
        end else begin
            return ffaa_pkg::ST_NOMEM;
        end
        in_use += gs;
        if (alloc_cnt < 65535) alloc_cnt++;
        ua = s + HDR;
        return ffaa_pkg::ST_OK;
    endfunction

    function logic [1:0] predict_free(longint unsigned addr, longint unsigned sz);
        longint unsigned s, ms, ml;
        int p, idx;
        bit lo, hi;
        if (addr < HDR) return ffaa_pkg::ST_BAD;
        s = addr - HDR;
        if (sz == 0 || sz % ALIGN != 0) return ffaa_pkg::ST_BAD;
        if (s < frontier || s + sz > arena_sz - HDR) return ffaa_pkg::ST_BAD;
        if (sz > in_use) return ffaa_pkg::ST_BAD;
        for (int i = 0; i < ext_cnt; i++)
            if (s < ext_start[i] + ext_len[i] && ext_start[i] < s + sz)
                return ffaa_pkg::ST_BAD;
        p = 0;
        while (p < ext_cnt && ext_start[p] > s) p++;
        lo = p < ext_cnt && ext_start[p] + ext_len[p] == s;
        hi = p > 0 && s + sz == ext_start[p-1];
        if (!lo && !hi && s != frontier && ext_cnt >= SLOTS) return ffaa_pkg::ST_FULL;
        if (!lo && !hi) begin
            if (s == frontier) frontier += sz;
            else insert_extent(p, s, sz);
        end else begin
            ms  = s;
            ml  = sz;
            idx = 0;
            if (lo) begin
                ms = ext_start[p];
                ml = ext_len[p] + sz;
                ext_len[p] = ml;
                idx = p;
            end
            if (hi) begin
                ml += ext_len[p-1];
                ext_start[p-1] = ms;
                ext_len[p-1]   = ml;
                if (lo) drop_extent(p);
                idx = p - 1;
            end
            if (ms == frontier) begin
                frontier += ml;
                drop_extent(idx);
            end
        end
        in_use -= sz;
        if (free_cnt < 65535) free_cnt++;
        return ffaa_pkg::ST_OK;
    endfunction

    // work out the expected result of one accepted item
    function void predict_item(logic cmd, logic [20:0] req, logic [19:0] addr,
                               logic [20:0] bsz);
        t_result r;
        longint unsigned ua, gs;
        ua = 0;
        gs = 0;
        if (cmd == ffaa_pkg::CMD_ALLOC) begin
            r.status = predict_alloc(req, ua, gs);
            if (r.status == ffaa_pkg::ST_OK) begin
                live_addr.push_back(ua[19:0]);
                live_size.push_back(gs[20:0]);
            end
        end else begin
            r.status = predict_free(addr, bsz);
        end
        r.user_address = ua[19:0];
        r.granted_size = gs[20:0];
        r.bytes_in_use = in_use[20:0];
        r.live_blocks  = alloc_cnt >= free_cnt ? 16'(alloc_cnt - free_cnt) : 16'd0;
        sb.note_item(r);
    endfunction

    // results are only valid for the one cycle o_done is high
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_status, o_user_address, o_granted_size,
                            o_bytes_in_use, o_live_blocks);
    end

    // watchdog on cycles with no item and no result accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WDOG) begin
            $display("timeout with %0d results pending", sb.pending.size());
            $display("FAIL");
            $finish;
        end
    end

    // offer one item, with a random idle gap first, and hold it until accepted;
    // start stays high after acceptance until the next gap, item or drain
    task automatic send_item(logic cmd, logic [20:0] req, logic [19:0] addr,
                             logic [20:0] bsz);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_request_size  <= req;
        i_block_address <= addr;
        i_block_size    <= bsz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_item(cmd, req, addr, bsz);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // arena size write, only with the block idle
    task automatic write_arena(logic [20:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        arena_reset(v);
    endtask

    // free a random live block, sometimes wrongly
    task automatic free_some(bit broken);
        int k;
        logic [19:0] a;
        logic [20:0] s;
        k = $urandom_range(live_addr.size() - 1);
        a = live_addr[k];
        s = live_size[k];
        if (broken) begin
            case ($urandom_range(3))
                0: s = s + 21'd8;
                1: a = a + 20'd16;
                2: s = 21'($urandom);
                default: a = 20'($urandom);
            endcase
        end else begin
            live_addr.delete(k);
            live_size.delete(k);
        end
        send_item(ffaa_pkg::CMD_FREE, 21'($urandom), a, s);
    endtask

    task automatic random_phase(int n, int max_req);
        for (int i = 0; i < n; i++) begin
            int r;
            r = $urandom_range(99);
            if (live_addr.size() != 0 && r < 45)
                free_some(1'b0);
            else if (live_addr.size() != 0 && r < 52)
                free_some(1'b1);
            else if (r < 56)
                send_item(ffaa_pkg::CMD_FREE, 21'($urandom), 20'($urandom), 21'($urandom));
            else if (r < 58)
                send_item(ffaa_pkg::CMD_ALLOC, 21'($urandom), 20'($urandom), 21'($urandom));
            else
                send_item(ffaa_pkg::CMD_ALLOC, 21'($urandom_range(max_req)), 20'($urandom),
                          21'($urandom));
        end
    endtask

    initial begin
        arena_reset(64'd1 << 20);
        idle_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: size extremes, zero request, bad frees, out of memory
        send_item(ffaa_pkg::CMD_ALLOC, 21'd0, 20'd0, 21'd0);
        send_item(ffaa_pkg::CMD_ALLOC, 21'd1, 20'hfffff, 21'h1fffff);
        send_item(ffaa_pkg::CMD_ALLOC, 21'd100, 20'd0, 21'd0);
        send_item(ffaa_pkg::CMD_ALLOC, 21'h1fffff, 20'd0, 21'd0);
        send_item(ffaa_pkg::CMD_ALLOC, 21'd1048576, 20'd0, 21'd0);
        send_item(ffaa_pkg::CMD_FREE, 21'd0, 20'd0, 21'd16);
        send_item(ffaa_pkg::CMD_FREE, 21'd0, 20'hfffff, 21'h1fffff);
        send_item(ffaa_pkg::CMD_FREE, 21'd0, live_addr[1], 21'd0);
        send_item(ffaa_pkg::CMD_FREE, 21'd0, live_addr[1], 21'd24);
        send_item(ffaa_pkg::CMD_FREE, 21'd0, live_addr[1], live_size[1]);
        send_item(ffaa_pkg::CMD_FREE, 21'd0, live_addr[1], live_size[1]);  // double free
        send_item(ffaa_pkg::CMD_FREE, 21'd0, live_addr[2], live_size[2]);  // merges to frontier
        send_item(ffaa_pkg::CMD_ALLOC, 21'd1048000, 20'd0, 21'd0);
        // fill the extent table with holes, then overflow it
        write_arena(21'd4096);
        for (int i = 0; i < 40; i++) send_item(ffaa_pkg::CMD_ALLOC, 21'd8, 20'd0, 21'd0);
        for (int i = 2; i < 40; i += 2)
            send_item(ffaa_pkg::CMD_FREE, 21'd0, live_addr[i], live_size[i]);
        send_item(ffaa_pkg::CMD_ALLOC, 21'd200000, 20'd0, 21'd0);
        live_addr.delete();
        live_size.delete();

        // random phases across arena sizes and idle rates
        write_arena(21'd0);
        idle_pct = 0;
        random_phase(96, 400);
        write_arena(21'h1fffff);
        idle_pct = 59;
        random_phase(96, 300000);
        drain();  // sender holds off until all results are in
        write_arena(21'd8192);
        idle_pct = 37;
        random_phase(96, 600);
        write_arena(21'd1048576);
        idle_pct = 0;
        random_phase(96, 2000);
        write_arena(21'd5000);
        idle_pct = 59;
        random_phase(96, 200);

        drain();
        $display("checked %0d results across several arena sizes and idle rates:",
                 sb.checked);
        $display("allocs, good and bad frees, out of memory and a full free table");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
